// File: rtl/ugrs_pkg.sv
// Shared constants, codes and state type for the uniform grid radius search unit.
package ugrs_pkg;

    // Grid geometry and list limits.
    localparam int GRID_MAX   = 16;
    localparam int CELL_SLOTS = 8;
    localparam int MAX_LIST   = 64;

    // Derived widths.
    localparam int CX_W     = $clog2(GRID_MAX);
    localparam int SIDE_W   = 5;
    localparam int NCELLS   = GRID_MAX * GRID_MAX;
    localparam int CELL_AW  = $clog2(NCELLS);
    localparam int SLOT_W   = $clog2(CELL_SLOTS);
    localparam int FILL_W   = 4;
    localparam int SLOT_AW  = CELL_AW + SLOT_W;
    localparam int ENTRY_W  = 52;
    localparam int LIST_AW  = $clog2(MAX_LIST);
    localparam int LIST_CW  = $clog2(MAX_LIST + 1);
    localparam int CNT_W    = 12;
    localparam int CNT_MAX  = 4095;
    localparam int ID_W     = 16;

    // Request codes.
    localparam logic [2:0] REQ_CLEAR   = 3'd0;
    localparam logic [2:0] REQ_INSERT  = 3'd1;
    localparam logic [2:0] REQ_LIST    = 3'd2;
    localparam logic [2:0] REQ_NEAREST = 3'd3;
    localparam logic [2:0] REQ_COUNT   = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HALF_WIDTH = 3'd0;
    localparam logic [2:0] CFG_HALF_DEPTH = 3'd1;
    localparam logic [2:0] CFG_INV_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_INV_DEPTH  = 3'd3;
    localparam logic [2:0] CFG_GRID_SIDE  = 3'd4;

    // Configuration reset values.
    localparam logic [14:0] HALF_RST = 15'd16384;
    localparam logic [15:0] INV_RST  = 16'd512;
    localparam logic [4:0]  SIDE_RST = 5'd16;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RSQ,
        ST_AX_MUL,
        ST_AX_CLAMP,
        ST_CELL_MUL,
        ST_CELL_ADDR,
        ST_FILL_RD,
        ST_FILL_GET,
        ST_SLOT_RD,
        ST_SLOT_GET,
        ST_DZ,
        ST_CMP,
        ST_NEXT_CELL,
        ST_RESULT,
        ST_LIST_RD,
        ST_LIST_OUT
    } state_t;

endpackage

// File: rtl/ugrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ugrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/uniform_grid_radius_search_unit.sv
// Uniform grid radius search unit: bucket grid with insert, clear and radius queries.
// One request is taken at a time; s_axis_tready is low until its last result is taken.
// Clear empties the grid and then offers its result. Insert stores a live point in its cell
// if the cell has a free slot. A list, nearest or count request walks each cell of the box
// that covers centre +/- radius and each stored point in those cells, all sequenced around
// one shared 18x18 multiplier and the single read port of the point store; a list then
// gives its results one at a time. Configuration writes are taken at any time
// (cfg_ready is always high) but are meant for idle periods only.
module uniform_grid_radius_search_unit
    import ugrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: pos_x[15:0], pos_z[31:16], radius[46:32], filter_on[47], kind[51:48],
    //        item_id[67:52], alive[68], zero[71:69]
    input  logic [71:0] s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: found_id[15:0], found[16], match_count[28:17], accepted[29],
    //        total_items[41:30], peak_occupancy[45:42], overflow[46], zero[47]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    // Configuration registers.
    logic [14:0]       half_width_reg, half_depth_reg;
    logic [15:0]       inv_width_reg, inv_depth_reg;
    logic [SIDE_W-1:0] grid_side_reg;

    // Control state.
    state_t             state_reg, state_next;
    logic [NCELLS-1:0]  cell_valid_reg, cell_valid_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [FILL_W-1:0]  peak_reg, peak_next;
    logic [1:0]         idx_reg, idx_next;
    logic [LIST_CW-1:0] n_reg, n_next;
    logic [LIST_AW-1:0] k_reg, k_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic               have_reg, have_next;

    // Request and datapath payload.
    logic [2:0]         req_reg, req_next;
    logic [15:0]        px_reg, px_next, pz_reg, pz_next;
    logic [14:0]        r_reg, r_next;
    logic               filt_reg, filt_next;
    logic [3:0]         kind_reg, kind_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic               alive_reg, alive_next;
    logic [29:0]        r2_reg, r2_next;
    logic [32:0]        best_reg, best_next;
    logic [ID_W-1:0]    best_id_reg, best_id_next;
    logic signed [35:0] prod_reg, prod_next;
    logic               axneg_reg, axneg_next;
    logic [CX_W-1:0]    x0_reg, x0_next, x1_reg, x1_next;
    logic [CX_W-1:0]    z0_reg, z0_next, z1_reg, z1_next;
    logic [CX_W-1:0]    cx_reg, cx_next, cz_reg, cz_next;
    logic [CELL_AW-1:0] cell_reg, cell_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic signed [17:0] dz_reg, dz_next;
    logic [31:0]        sq_reg, sq_next;
    logic [ID_W-1:0]    eid_reg, eid_next;
    logic               kmatch_reg, kmatch_next;

    // Result register.
    logic [ID_W-1:0]    o_id_reg, o_id_next;
    logic               o_found_reg, o_found_next;
    logic [CNT_W-1:0]   o_cnt_reg, o_cnt_next;
    logic               o_acc_reg, o_acc_next;
    logic               o_ovf_reg, o_ovf_next;
    logic               o_last_reg, o_last_next;

    // Shared multiplier.
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;

    // Memory ports.
    logic               slot_we, fill_we, ids_we;
    logic [ENTRY_W-1:0] slot_wdata, slot_rdata;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [FILL_W-1:0]  fill_wdata, fill_rdata;
    logic [ID_W-1:0]    ids_rdata;

    // Combinational helpers.
    logic [SIDE_W-1:0]  side;
    logic [CX_W-1:0]    side_m1;
    logic signed [17:0] ax_base, ax_s;
    logic [17:0]        ax_r, ax_half;
    logic [15:0]        ax_c16;
    logic [CX_W-1:0]    ax_cell;
    logic [FILL_W-1:0]  fill_now;
    logic signed [17:0] dx_now;
    logic [32:0]        d2;
    logic [ID_W-1:0]    slot_id;
    logic [15:0]        slot_x, slot_z;
    logic [3:0]         slot_kind;

    assign cfg_ready = 1'b1;

    // Grid side in use, clamped to 1..GRID_MAX.
    always_comb
    begin
        if (grid_side_reg == '0)
        begin
            side = SIDE_W'(1);
        end
        else if (grid_side_reg > SIDE_W'(GRID_MAX))
        begin
            side = SIDE_W'(GRID_MAX);
        end
        else
        begin
            side = grid_side_reg;
        end
    end
    assign side_m1 = CX_W'(side - SIDE_W'(1));

    // Axis offset: coordinate -/+ radius plus the half extent of that axis.
    assign ax_base = idx_reg[1] ? {{2{pz_reg[15]}}, pz_reg} : {{2{px_reg[15]}}, px_reg};
    assign ax_r    = 18'(r_reg);
    assign ax_half = idx_reg[1] ? 18'(half_depth_reg) : 18'(half_width_reg);
    assign ax_s    = idx_reg[0] ? (ax_base + ax_r + ax_half) : (ax_base - ax_r + ax_half);

    // Cell index from the scaled product, clamped to the first and last cells.
    assign ax_c16  = prod_reg[35:20];
    assign ax_cell = axneg_reg ? '0 :
                     (ax_c16 > 16'(side_m1)) ? side_m1 : ax_c16[CX_W-1:0];

    // Fill of the addressed cell: a cell not written since clear holds nothing.
    assign fill_now = cell_valid_reg[cell_reg] ? fill_rdata : '0;

    // Stored point fields.
    assign slot_id   = slot_rdata[15:0];
    assign slot_x    = slot_rdata[31:16];
    assign slot_z    = slot_rdata[47:32];
    assign slot_kind = slot_rdata[51:48];
    assign dx_now    = {{2{slot_x[15]}}, slot_x} - {{2{px_reg[15]}}, px_reg};
    assign d2        = {1'b0, sq_reg} + {1'b0, prod_reg[31:0]};

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_RSQ:
            begin
                mul_a = 18'(r_reg);
                mul_b = 18'(r_reg);
            end
            ST_AX_MUL:
            begin
                mul_a = ax_s;
                mul_b = idx_reg[1] ? 18'(inv_depth_reg) : 18'(inv_width_reg);
            end
            ST_CELL_MUL:
            begin
                mul_a = 18'(cz_reg);
                mul_b = 18'(side);
            end
            ST_SLOT_GET:
            begin
                mul_a = dx_now;
                mul_b = dx_now;
            end
            ST_DZ:
            begin
                mul_a = dz_reg;
                mul_b = dz_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Sequencer: next state, datapath updates and memory writes.
    always_comb
    begin
        state_next      = state_reg;
        cell_valid_next = cell_valid_reg;
        total_next      = total_reg;
        peak_next       = peak_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        have_next       = have_reg;
        req_next        = req_reg;
        px_next         = px_reg;
        pz_next         = pz_reg;
        r_next          = r_reg;
        filt_next       = filt_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        alive_next      = alive_reg;
        r2_next         = r2_reg;
        best_next       = best_reg;
        best_id_next    = best_id_reg;
        prod_next       = prod_reg;
        axneg_next      = axneg_reg;
        x0_next         = x0_reg;
        x1_next         = x1_reg;
        z0_next         = z0_reg;
        z1_next         = z1_reg;
        cx_next         = cx_reg;
        cz_next         = cz_reg;
        cell_next       = cell_reg;
        fill_next       = fill_reg;
        slot_next       = slot_reg;
        dz_next         = dz_reg;
        sq_next         = sq_reg;
        eid_next        = eid_reg;
        kmatch_next     = kmatch_reg;
        o_id_next       = o_id_reg;
        o_found_next    = o_found_reg;
        o_cnt_next      = o_cnt_reg;
        o_acc_next      = o_acc_reg;
        o_ovf_next      = o_ovf_reg;
        o_last_next     = o_last_reg;
        slot_we         = 1'b0;
        fill_we         = 1'b0;
        ids_we          = 1'b0;
        slot_waddr      = {cell_reg, fill_now[SLOT_W-1:0]};
        slot_wdata      = {kind_reg, pz_reg, px_reg, id_reg};
        fill_wdata      = fill_now + FILL_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next     = s_axis_tuser;
                    px_next      = s_axis_tdata[15:0];
                    pz_next      = s_axis_tdata[31:16];
                    r_next       = (s_axis_tuser == REQ_INSERT) ? '0 : s_axis_tdata[46:32];
                    filt_next    = s_axis_tdata[47];
                    kind_next    = s_axis_tdata[51:48];
                    id_next      = s_axis_tdata[67:52];
                    alive_next   = s_axis_tdata[68];
                    idx_next     = '0;
                    n_next       = '0;
                    cnt_next     = '0;
                    ovf_next     = 1'b0;
                    have_next    = 1'b0;
                    best_id_next = '0;
                    o_id_next    = '0;
                    o_found_next = 1'b0;
                    o_cnt_next   = '0;
                    o_acc_next   = 1'b0;
                    o_ovf_next   = 1'b0;
                    o_last_next  = 1'b1;
                    if (s_axis_tuser == REQ_CLEAR)
                    begin
                        cell_valid_next = '0;
                        total_next      = '0;
                        peak_next       = '0;
                        state_next      = ST_RESULT;
                    end
                    else if (s_axis_tuser == REQ_INSERT || s_axis_tuser == REQ_LIST ||
                             s_axis_tuser == REQ_NEAREST || s_axis_tuser == REQ_COUNT)
                    begin
                        state_next = ST_RSQ;
                    end
                end
            end
            ST_RSQ:
            begin
                r2_next    = mul_p[29:0];
                best_next  = 33'(mul_p[29:0]);
                state_next = ST_AX_MUL;
            end
            ST_AX_MUL:
            begin
                prod_next  = mul_p;
                axneg_next = ax_s[17];
                state_next = ST_AX_CLAMP;
            end
            ST_AX_CLAMP:
            begin
                case (idx_reg)
                    2'd0:    x0_next = ax_cell;
                    2'd1:    x1_next = ax_cell;
                    2'd2:    z0_next = ax_cell;
                    default: z1_next = ax_cell;
                endcase
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    cx_next    = x0_reg;
                    cz_next    = z0_reg;
                    state_next = ST_CELL_MUL;
                end
                else
                begin
                    state_next = ST_AX_MUL;
                end
            end
            ST_CELL_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_CELL_ADDR;
            end
            ST_CELL_ADDR:
            begin
                cell_next  = prod_reg[CELL_AW-1:0] + CELL_AW'(cx_reg);
                state_next = ST_FILL_RD;
            end
            ST_FILL_RD:
            begin
                state_next = ST_FILL_GET;
            end
            ST_FILL_GET:
            begin
                if (req_reg == REQ_INSERT)
                begin
                    // Store the point if it is alive and the cell has a free slot.
                    if (alive_reg && fill_now < FILL_W'(CELL_SLOTS))
                    begin
                        slot_we                   = 1'b1;
                        fill_we                   = 1'b1;
                        cell_valid_next[cell_reg] = 1'b1;
                        o_acc_next                = 1'b1;
                        if (total_reg != CNT_W'(CNT_MAX))
                        begin
                            total_next = total_reg + CNT_W'(1);
                        end
                        if (fill_wdata > peak_reg)
                        begin
                            peak_next = fill_wdata;
                        end
                    end
                    state_next = ST_RESULT;
                end
                else
                begin
                    fill_next  = fill_now;
                    slot_next  = '0;
                    state_next = (fill_now == '0) ? ST_NEXT_CELL : ST_SLOT_RD;
                end
            end
            ST_SLOT_RD:
            begin
                state_next = ST_SLOT_GET;
            end
            ST_SLOT_GET:
            begin
                prod_next   = mul_p;
                dz_next     = {{2{slot_z[15]}}, slot_z} - {{2{pz_reg[15]}}, pz_reg};
                eid_next    = slot_id;
                kmatch_next = !filt_reg || (slot_kind == kind_reg);
                state_next  = ST_DZ;
            end
            ST_DZ:
            begin
                sq_next    = prod_reg[31:0];
                prod_next  = mul_p;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (kmatch_reg)
                begin
                    if (req_reg == REQ_LIST)
                    begin
                        if (d2 <= 33'(r2_reg))
                        begin
                            if (n_reg < LIST_CW'(MAX_LIST))
                            begin
                                ids_we = 1'b1;
                                n_next = n_reg + LIST_CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                    else if (req_reg == REQ_NEAREST)
                    begin
                        if (d2 < best_reg && d2 != '0)
                        begin
                            best_next    = d2;
                            best_id_next = eid_reg;
                            have_next    = 1'b1;
                        end
                    end
                    else
                    begin
                        if (d2 <= 33'(r2_reg) && cnt_reg != CNT_W'(CNT_MAX))
                        begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                end
                slot_next = slot_reg + SLOT_W'(1);
                if (FILL_W'(slot_reg) + FILL_W'(1) < fill_reg)
                begin
                    state_next = ST_SLOT_RD;
                end
                else
                begin
                    state_next = ST_NEXT_CELL;
                end
            end
            ST_NEXT_CELL:
            begin
                if (cx_reg < x1_reg)
                begin
                    cx_next    = cx_reg + CX_W'(1);
                    state_next = ST_CELL_MUL;
                end
                else if (cz_reg < z1_reg)
                begin
                    cx_next    = x0_reg;
                    cz_next    = cz_reg + CX_W'(1);
                    state_next = ST_CELL_MUL;
                end
                else if (req_reg == REQ_LIST)
                begin
                    k_next     = '0;
                    state_next = (n_reg == '0) ? ST_RESULT : ST_LIST_RD;
                end
                else if (req_reg == REQ_NEAREST)
                begin
                    o_id_next    = have_reg ? best_id_reg : '0;
                    o_found_next = have_reg;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    o_cnt_next = cnt_reg;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIST_RD:
            begin
                // The list memory was addressed with entry k on the edge that entered here.
                o_id_next    = ids_rdata;
                o_found_next = 1'b1;
                o_ovf_next   = ovf_reg;
                o_last_next  = (LIST_CW'(k_reg) + LIST_CW'(1)) == n_reg;
                state_next   = ST_LIST_OUT;
            end
            ST_LIST_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (o_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + LIST_AW'(1);
                        state_next = ST_LIST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= HALF_RST;
            half_depth_reg <= HALF_RST;
            inv_width_reg  <= INV_RST;
            inv_depth_reg  <= INV_RST;
            grid_side_reg  <= SIDE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HALF_WIDTH: half_width_reg <= cfg_data[14:0];
                CFG_HALF_DEPTH: half_depth_reg <= cfg_data[14:0];
                CFG_INV_WIDTH:  inv_width_reg  <= cfg_data;
                CFG_INV_DEPTH:  inv_depth_reg  <= cfg_data;
                CFG_GRID_SIDE:  grid_side_reg  <= cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cell_valid_reg <= '0;
            total_reg      <= '0;
            peak_reg       <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            have_reg       <= 1'b0;
            req_reg        <= REQ_CLEAR;
            o_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cell_valid_reg <= cell_valid_next;
            total_reg      <= total_next;
            peak_reg       <= peak_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            k_reg          <= k_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            have_reg       <= have_next;
            req_reg        <= req_next;
            o_last_reg     <= o_last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        pz_reg      <= pz_next;
        r_reg       <= r_next;
        filt_reg    <= filt_next;
        kind_reg    <= kind_next;
        id_reg      <= id_next;
        alive_reg   <= alive_next;
        r2_reg      <= r2_next;
        best_reg    <= best_next;
        best_id_reg <= best_id_next;
        prod_reg    <= prod_next;
        axneg_reg   <= axneg_next;
        x0_reg      <= x0_next;
        x1_reg      <= x1_next;
        z0_reg      <= z0_next;
        z1_reg      <= z1_next;
        cx_reg      <= cx_next;
        cz_reg      <= cz_next;
        cell_reg    <= cell_next;
        fill_reg    <= fill_next;
        slot_reg    <= slot_next;
        dz_reg      <= dz_next;
        sq_reg      <= sq_next;
        eid_reg     <= eid_next;
        kmatch_reg  <= kmatch_next;
        o_id_reg    <= o_id_next;
        o_found_reg <= o_found_next;
        o_cnt_reg   <= o_cnt_next;
        o_acc_reg   <= o_acc_next;
        o_ovf_reg   <= o_ovf_next;
    end

    // Point store: one entry per cell slot.
    ugrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NCELLS * CELL_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr ({cell_reg, slot_reg}),
        .rdata (slot_rdata)
    );

    // Cell fill counts, qualified by the valid bits.
    ugrs_ram #(
        .WIDTH (FILL_W),
        .DEPTH (NCELLS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (cell_reg),
        .wdata (fill_wdata),
        .raddr (cell_reg),
        .rdata (fill_rdata)
    );

    // Matched ids of a list request, held until the walk ends.
    // The read address runs one step ahead so entry k is ready in ST_LIST_RD.
    ugrs_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_LIST)
    ) u_ids_ram (
        .clk   (clk),
        .we    (ids_we),
        .waddr (n_reg[LIST_AW-1:0]),
        .wdata (eid_reg),
        .raddr (k_next),
        .rdata (ids_rdata)
    );

    // Handshake outputs and result packing.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_RESULT) || (state_reg == ST_LIST_OUT);
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {1'b0, o_ovf_reg, peak_reg, total_reg, o_acc_reg,
                            o_cnt_reg, o_found_reg, o_id_reg};

endmodule

// File: rtl/ugrs_checker.sv
// Port-level assertions for the uniform grid radius search unit, bound to the top level.
module ugrs_checker
    import ugrs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A request is never taken while a result is on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request accepted while a result is pending");

    // Once a known request is taken the block is busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser <= REQ_COUNT)) |=> !s_axis_tready)
        else $error("ready stayed high after a request was taken");

    // A result that is not the last one is followed by more work, not a new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
        else $error("ready rose before the last result of a list");

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // A result without a match carries a zero id.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[16]) |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("id set on a result without a match");

endmodule

bind uniform_grid_radius_search_unit ugrs_checker u_ugrs_checker (.*);
